// ===== src/bsa_pkg.sv =====
package bsa_pkg;

  // store geometry
  localparam int WORD_BITS   = 32;
  localparam int NUM_WORDS   = 64;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int ADDR_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TOTAL_SLOTS = NUM_WORDS * WORD_BITS;

  // field widths
  localparam int MODE_W   = 2;
  localparam int POS_W    = 11;
  localparam int CNT_W    = 12;
  localparam int STATUS_W = 3;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 12'd2048;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET,
    MODE_UNSET,
    MODE_CHECK,
    MODE_RESERVE
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_RANGE,
    ST_ALREADY_SET,
    ST_NOT_SET,
    ST_FULL
  } status_t;

  // one read port and one write port into the slot store
  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } ram_req_t;

endpackage

// ===== src/bsa_if.sv =====
interface bsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bsa_pkg::MODE_W-1:0]  mode;
  logic [bsa_pkg::POS_W-1:0]   bit_pos;

  modport source (output valid, output mode, output bit_pos, input ready);
  modport sink (input valid, input mode, input bit_pos, output ready);
endinterface

interface bsa_res_if;
  logic                         valid;
  logic                         ready;
  logic [bsa_pkg::STATUS_W-1:0] status;
  logic                         bit_value;
  logic [bsa_pkg::POS_W-1:0]    position;
  logic [bsa_pkg::CNT_W-1:0]    used_count;
  logic                         full_res;

  modport source (output valid, output status, output bit_value, output position,
                  output used_count, output full_res, input ready);
  modport sink (input valid, input status, input bit_value, input position,
                input used_count, input full_res, output ready);
endinterface

interface bsa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bsa_pkg::CNT_W-1:0] slot_limit;

  modport source (output valid, output slot_limit, input ready);
  modport sink (input valid, input slot_limit, output ready);
endinterface

// ===== src/bitmap_slot_allocator.sv =====
// set, unset, check: read, evaluate and write-back of one store word, then the result
// is loaded into the output register, which waits while an untaken result is held
// reserve: k words searched when the free slot lies in the k-th word searched, k up to
// NUM_WORDS + 1, one word per cycle; a new request is taken only once the result is loaded
// range error or full at request time: no store access, the result goes to the output
// rst (synchronous) clears used count, word valid flags and output; limit returns to 2048
module bitmap_slot_allocator (
  input  logic       clk,
  input  logic       rst,
  bsa_req_if.sink    req,
  bsa_res_if.source  res,
  bsa_cfg_if.sink    cfg
);

  logic [bsa_pkg::CNT_W-1:0]     slot_limit;
  bsa_pkg::ram_req_t             ram_req;
  logic [bsa_pkg::WORD_BITS-1:0] ram_rdata;

  // limit register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= bsa_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      slot_limit <= cfg.slot_limit;
    end
  end

  bsa_slot_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .ram   (ram_req),
    .rdata (ram_rdata)
  );

  bsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .res        (res),
    .slot_limit (slot_limit),
    .ram        (ram_req),
    .ram_rdata  (ram_rdata)
  );

  // store is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.rd_en && ram_req.wr_en))
    else $error("slot store read and write in one cycle");

  // no write-back while a new request is taken
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !ram_req.wr_en)
    else $error("slot store written while idle");

  // at most one write-back per request, checked as no write-back right after another
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |=> !ram_req.wr_en)
    else $error("slot store written twice in a row");

endmodule

// ===== src/bsa_slot_ram.sv =====
module bsa_slot_ram (
  input  logic                            clk,
  input  logic                            rst,
  input  bsa_pkg::ram_req_t               ram,
  output logic [bsa_pkg::WORD_BITS-1:0]   rdata
);

  logic [bsa_pkg::WORD_BITS-1:0] mem [bsa_pkg::NUM_WORDS];
  logic [bsa_pkg::WORD_BITS-1:0] mem_q;
  logic [bsa_pkg::NUM_WORDS-1:0] vld;
  logic                          vld_q;

  // word storage, registered read
  always_ff @(posedge clk) begin
    if (ram.wr_en) begin
      mem[ram.wr_addr] <= ram.wr_data;
    end
    if (ram.rd_en) begin
      mem_q <= mem[ram.rd_addr];
    end
  end

  // per-word written flags, a word never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ram.wr_en) begin
        vld[ram.wr_addr] <= 1'b1;
      end
      if (ram.rd_en) begin
        vld_q <= vld[ram.rd_addr];
      end
    end
  end

  assign rdata = vld_q ? mem_q : '0;

endmodule

// ===== src/bsa_ctrl.sv =====
module bsa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  bsa_req_if.sink                       req,
  bsa_res_if.source                     res,
  input  logic [bsa_pkg::CNT_W-1:0]     slot_limit,
  output bsa_pkg::ram_req_t             ram,
  input  logic [bsa_pkg::WORD_BITS-1:0] ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                            state;
  bsa_pkg::mode_t                    mode_q;
  logic [bsa_pkg::POS_W-1:0]         pos_q;
  logic [bsa_pkg::CNT_W-1:0]         lim;
  logic [bsa_pkg::CNT_W-1:0]         used;
  bsa_pkg::status_t                  res_status;
  logic                              res_bit;
  logic [bsa_pkg::POS_W-1:0]         res_pos;

  // scan issue and evaluate stages
  logic [bsa_pkg::ADDR_W-1:0]        iss_word;
  logic                              iss_wrap;
  logic                              iss_more;
  logic                              ev_valid;
  logic [bsa_pkg::ADDR_W-1:0]        ev_word;
  logic                              ev_wrap;
  logic                              ev_final;

  // output register
  logic                              out_valid;
  bsa_pkg::status_t                  out_status;
  logic                              out_bit;
  logic [bsa_pkg::POS_W-1:0]         out_pos;
  logic [bsa_pkg::CNT_W-1:0]         out_used;
  logic                              out_full;

  logic [bsa_pkg::CNT_W-1:0]         lim_eff;
  logic [bsa_pkg::BIT_W-1:0]         start_bit;
  logic [bsa_pkg::ADDR_W-1:0]        start_word;
  logic [bsa_pkg::ADDR_W-1:0]        last_word;
  logic [bsa_pkg::BIT_W:0]           last_bits;
  logic [bsa_pkg::WORD_BITS-1:0]     scan_mask;
  logic [bsa_pkg::WORD_BITS-1:0]     free_bits;
  logic                              found;
  logic [bsa_pkg::BIT_W-1:0]         free_idx;
  logic                              ev_hit;
  logic [bsa_pkg::ADDR_W-1:0]        pos_word;
  logic [bsa_pkg::BIT_W-1:0]         pos_bit;
  logic                              cur_bit;
  logic [bsa_pkg::WORD_BITS-1:0]     pos_mask;

  // limit clipped to the store size
  assign lim_eff = (32'(slot_limit) < bsa_pkg::TOTAL_SLOTS) ? slot_limit
                 : bsa_pkg::CNT_W'(bsa_pkg::TOTAL_SLOTS);

  // search window: from the used count up to the limit, then wrap below it
  assign start_bit  = used[bsa_pkg::BIT_W-1:0];
  assign start_word = bsa_pkg::ADDR_W'(used >> bsa_pkg::BIT_W);
  assign last_word  = bsa_pkg::ADDR_W'((lim - 1'b1) >> bsa_pkg::BIT_W);
  assign last_bits  = (bsa_pkg::BIT_W + 1)'(lim -
                      (bsa_pkg::CNT_W'(last_word) << bsa_pkg::BIT_W));

  // mask of searchable bits in the word under evaluation
  always_comb begin
    for (int i = 0; i < bsa_pkg::WORD_BITS; i++) begin
      scan_mask[i] = ((ev_word != last_word) || ((bsa_pkg::BIT_W + 1)'(i) < last_bits)) &&
                     ((ev_word != start_word) ||
                      (ev_wrap ? (bsa_pkg::BIT_W'(i) < start_bit)
                               : (bsa_pkg::BIT_W'(i) >= start_bit)));
    end
  end

  assign free_bits = ~ram_rdata & scan_mask;
  assign found     = |free_bits;

  // lowest free bit
  always_comb begin
    free_idx = '0;
    for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_idx = bsa_pkg::BIT_W'(i);
      end
    end
  end

  assign ev_hit = (state == S_SCAN) && ev_valid && found;

  // named slot access
  assign pos_word = bsa_pkg::ADDR_W'(pos_q >> bsa_pkg::BIT_W);
  assign pos_bit  = pos_q[bsa_pkg::BIT_W-1:0];
  assign cur_bit  = ram_rdata[pos_bit];
  assign pos_mask = bsa_pkg::WORD_BITS'(1) << pos_bit;

  // store port requests
  always_comb begin
    ram = '0;
    unique case (state)
      S_READ: begin
        ram.rd_en   = 1'b1;
        ram.rd_addr = pos_word;
      end
      S_EVAL: begin
        ram.wr_addr = pos_word;
        if (mode_q == bsa_pkg::MODE_SET && !cur_bit) begin
          ram.wr_en   = 1'b1;
          ram.wr_data = ram_rdata | pos_mask;
        end else if (mode_q == bsa_pkg::MODE_UNSET && cur_bit) begin
          ram.wr_en   = 1'b1;
          ram.wr_data = ram_rdata & ~pos_mask;
        end
      end
      S_SCAN: begin
        ram.rd_en   = iss_more && !ev_hit;
        ram.rd_addr = iss_word;
        ram.wr_addr = ev_word;
        ram.wr_data = ram_rdata | (bsa_pkg::WORD_BITS'(1) << free_idx);
        ram.wr_en   = ev_hit;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      iss_more  <= 1'b0;
      ev_valid  <= 1'b0;
    end else begin
      if (out_valid && res.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode_q     <= bsa_pkg::mode_t'(req.mode);
            pos_q      <= req.bit_pos;
            lim        <= lim_eff;
            res_bit    <= 1'b0;
            res_pos    <= req.bit_pos;
            if (bsa_pkg::mode_t'(req.mode) == bsa_pkg::MODE_RESERVE) begin
              if (used >= lim_eff) begin
                res_status <= bsa_pkg::ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= bsa_pkg::ST_OK;
                iss_word   <= start_word;
                iss_wrap   <= 1'b0;
                iss_more   <= 1'b1;
                ev_valid   <= 1'b0;
                state      <= S_SCAN;
              end
            end else if (bsa_pkg::CNT_W'(req.bit_pos) >= lim_eff) begin
              res_status <= bsa_pkg::ST_RANGE;
              state      <= S_DONE;
            end else begin
              res_status <= bsa_pkg::ST_OK;
              state      <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          unique case (mode_q)
            bsa_pkg::MODE_SET: begin
              if (cur_bit) begin
                res_status <= bsa_pkg::ST_ALREADY_SET;
              end else begin
                used <= used + 1'b1;
              end
            end
            bsa_pkg::MODE_UNSET: begin
              if (!cur_bit) begin
                res_status <= bsa_pkg::ST_NOT_SET;
              end else begin
                used <= used - 1'b1;
              end
            end
            bsa_pkg::MODE_CHECK: begin
              res_bit <= cur_bit;
            end
            bsa_pkg::MODE_RESERVE: begin
            end
          endcase
          state <= S_DONE;
        end
        S_SCAN: begin
          // issue side: walk words up to the last, then wrap back to the start word
          ev_valid <= iss_more;
          ev_word  <= iss_word;
          ev_wrap  <= iss_wrap;
          ev_final <= iss_wrap && (iss_word == start_word);
          if (iss_more && !ev_hit) begin
            if (iss_wrap && iss_word == start_word) begin
              iss_more <= 1'b0;
            end else if (iss_word == last_word) begin
              iss_word <= '0;
              iss_wrap <= 1'b1;
            end else begin
              iss_word <= iss_word + 1'b1;
            end
          end
          // evaluate side
          if (ev_valid) begin
            if (found) begin
              used     <= used + 1'b1;
              res_pos  <= bsa_pkg::POS_W'({ev_word, free_idx});
              iss_more <= 1'b0;
              state    <= S_DONE;
            end else if (ev_final) begin
              res_status <= bsa_pkg::ST_FULL;
              state      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_bit    <= res_bit;
            out_pos    <= res_pos;
            out_used   <= used;
            out_full   <= (used >= lim);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.bit_value  = out_bit;
  assign res.position   = out_pos;
  assign res.used_count = out_used;
  assign res.full_res   = out_full;

endmodule
